// ===== rtl/rcp_pkg.sv =====
// ----------------------------------------------------------------------------
// rcp_pkg: rhythm chart text parser shared definitions
// Event and mode codes, character constants and the per-byte event record.
// ----------------------------------------------------------------------------
`default_nettype none

package rcp_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int SPAN_W            = 32;
    localparam int ROW_W             = 32;
    localparam int HEADER_COUNT      = 5;
    localparam int NOTES_LEN         = 5;
    localparam int EVQ_DEPTH         = 4;
    localparam int EVQ_PTR_W         = $clog2(EVQ_DEPTH);
    localparam int EVQ_CNT_W         = $clog2(EVQ_DEPTH + 1);

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        EV_HEADER       = 3'd0,
        EV_CHART_START  = 3'd1,
        EV_CHART_HEADER = 3'd2,
        EV_MEASURE_END  = 3'd3,
        EV_ROW          = 3'd4,
        EV_CHART_END    = 3'd5,
        EV_VERDICT      = 3'd6
    } t_event;

    typedef enum logic [3:0] {
        MODE_SCAN     = 4'd0,
        MODE_NAME     = 4'd1,
        MODE_VALUE    = 4'd2,
        MODE_CH_WS    = 4'd3,
        MODE_CH_TEXT  = 4'd4,
        MODE_MEASURES = 4'd5,
        MODE_SLASH    = 4'd6,
        MODE_COMMENT  = 4'd7,
        MODE_ROW      = 4'd8,
        MODE_ROW_SKIP = 4'd9
    } t_mode;

    // All events caused by one byte: a main event, an optional measure or
    // chart end after a row, and the verdict on the final byte.
    typedef struct packed {
        logic                has_main;
        t_event              main_kind;
        logic [SPAN_W-1:0]   s1;
        logic [SPAN_W-1:0]   l1;
        logic [SPAN_W-1:0]   s2;
        logic [SPAN_W-1:0]   l2;
        logic [2:0]          hdr_idx;
        logic [ROW_W-1:0]    row;
        logic                has_second;
        t_event              second_kind;
        logic                has_verdict;
        logic                verdict;
    } t_run;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) ||
               (b == 8'h0B) || (b == 8'h0C);
    endfunction

    function automatic logic [7:0] notes_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0:    c = 8'h4E;
            3'd1:    c = 8'h4F;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h45;
            3'd4:    c = 8'h53;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rcp_in_if.sv =====
// ----------------------------------------------------------------------------
// rcp_in_if: byte request channel
// Valid/ready channel carrying one text byte and its last-byte mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/rcp_out_if.sv =====
// ----------------------------------------------------------------------------
// rcp_out_if: parse event channel
// Valid/ready channel carrying one parse event.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [31:0] first_span_start;
    logic [31:0] first_span_length;
    logic [31:0] second_span_start;
    logic [31:0] second_span_length;
    logic [2:0]  chart_header_index;
    logic [31:0] row_characters;
    logic        file_valid;
    logic        last_of_run;

    modport source (
        output valid, input ready,
        output event_kind, output first_span_start, output first_span_length,
        output second_span_start, output second_span_length,
        output chart_header_index, output row_characters, output file_valid,
        output last_of_run
    );
    modport sink (
        input valid, output ready,
        input event_kind, input first_span_start, input first_span_length,
        input second_span_start, input second_span_length,
        input chart_header_index, input row_characters, input file_valid,
        input last_of_run
    );
endinterface

`default_nettype wire

// ===== rtl/rcp_evq.sv =====
// ----------------------------------------------------------------------------
// rcp_evq: event queue and sequencer
// Holds per-byte event records and hands out their events one per request.
// ----------------------------------------------------------------------------
`default_nettype none

module rcp_evq (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  rcp_pkg::t_run  i_run,
    output logic           o_ready,
    rcp_out_if.source      o_out
);

    rcp_pkg::t_run                     r_mem [rcp_pkg::EVQ_DEPTH];
    logic [rcp_pkg::EVQ_PTR_W-1:0]     r_wr_ptr;
    logic [rcp_pkg::EVQ_PTR_W-1:0]     r_rd_ptr;
    logic [rcp_pkg::EVQ_CNT_W-1:0]     r_count;
    logic [2:0]                        r_done;

    rcp_pkg::t_run head;
    logic [2:0]    flags;
    logic [2:0]    rem;
    logic [2:0]    cur;
    logic          last;
    logic          fire;
    logic          pop;

    localparam logic [rcp_pkg::EVQ_PTR_W-1:0] PTR_LAST =
        rcp_pkg::EVQ_PTR_W'(rcp_pkg::EVQ_DEPTH - 1);
    localparam logic [rcp_pkg::EVQ_CNT_W-1:0] CNT_FULL =
        rcp_pkg::EVQ_CNT_W'(rcp_pkg::EVQ_DEPTH);

    always_comb begin
        head  = r_mem[r_rd_ptr];
        flags = {head.has_verdict, head.has_second, head.has_main};
        rem   = flags & ~r_done;
        cur   = rem & (~rem + 3'd1);       // lowest pending event
        last  = (rem & ~cur) == 3'b000;
        fire  = o_out.valid && o_out.ready;
        pop   = fire && last;
        o_ready = r_count < CNT_FULL;
    end

    always_comb begin
        o_out.valid              = r_count != '0;
        o_out.event_kind         = cur[0] ? head.main_kind :
                                   cur[1] ? head.second_kind : rcp_pkg::EV_VERDICT;
        o_out.first_span_start   = cur[0] ? head.s1 : '0;
        o_out.first_span_length  = cur[0] ? head.l1 : '0;
        o_out.second_span_start  = cur[0] ? head.s2 : '0;
        o_out.second_span_length = cur[0] ? head.l2 : '0;
        o_out.chart_header_index = cur[0] ? head.hdr_idx : '0;
        o_out.row_characters     = cur[0] ? head.row : '0;
        o_out.file_valid         = cur[2] & head.verdict;
        o_out.last_of_run        = last;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_done   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
                r_done   <= '0;
            end else if (fire) begin
                r_done   <= r_done | cur;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("event queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CNT_FULL))
        else $error("record pushed into full event queue");
    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> ((r_done & ~flags) == 3'b000) && (rem != 3'b000))
        else $error("sequencer progress outside head record");
    a_partial_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !last) |=> $stable(r_rd_ptr) && (r_count != '0))
        else $error("head record left before its last event");
`endif

endmodule

`default_nettype wire

// ===== rtl/rhythm_chart_text_parser.sv =====
// ----------------------------------------------------------------------------
// rhythm_chart_text_parser: streaming chart text parser
// Turns a chart text byte stream into header, chart and row parse events.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock on i_in while i_in.ready is high and
// registers its new state as the byte is taken; the events a byte causes (at
// most two: a main event such as a row, plus either a following measure or
// chart end or the verdict on the final byte) are written as one record into
// a four-entry event queue and show on o_out behind any older records, one
// event per cycle while o_out.ready is high. A byte that causes no event
// writes nothing into the queue. i_in.ready drops only while the event queue
// is full, so new bytes are taken while older events still wait. After the final
// byte the parser is back in its reset state and offsets restart at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rhythm_chart_text_parser #(
    parameter int POSITION_BITS = rcp_pkg::POSITION_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rcp_in_if.sink     i_in,
    rcp_out_if.source  o_out
);

    localparam int PB = POSITION_BITS;

    rcp_pkg::t_mode    r_mode,       n_mode;
    logic [PB-1:0]     r_pos,        n_pos;
    logic [PB-1:0]     r_span_begin, n_span_begin;
    logic [PB-1:0]     r_name_begin, n_name_begin;
    logic [PB-1:0]     r_name_len,   n_name_len;
    logic [2:0]        r_kw_idx,     n_kw_idx;
    logic              r_kw_miss,    n_kw_miss;
    logic [2:0]        r_hdr_cnt,    n_hdr_cnt;
    logic [23:0]       r_row_buf,    n_row_buf;
    logic [1:0]        r_row_fill,   n_row_fill;
    logic              r_any_hdr,    n_any_hdr;
    logic              r_any_chart,  n_any_chart;
    logic              r_err,        n_err;

    rcp_pkg::t_run     run;
    rcp_pkg::t_event   mb_kind;
    rcp_pkg::t_mode    mb_mode;
    logic              mb_emit;
    logic              mb_row;
    logic              ch_done;
    logic [PB-1:0]     ch_begin;
    logic [7:0]        b;
    logic              fin;
    logic              in_fire;
    logic              push;
    logic              evq_ready;

    function automatic logic [rcp_pkg::SPAN_W-1:0] to_span(input logic [PB-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[rcp_pkg::SPAN_W-1:0];
    endfunction

    assign i_in.ready = evq_ready;
    assign in_fire    = i_in.valid && evq_ready;
    assign b          = i_in.data_byte;
    assign fin        = i_in.final_byte;

    // Measure-level decode of the current byte, shared by several modes.
    always_comb begin
        mb_emit = 1'b0;
        mb_kind = rcp_pkg::EV_MEASURE_END;
        mb_mode = rcp_pkg::MODE_MEASURES;
        mb_row  = 1'b0;
        if (b == rcp_pkg::CH_SEMI) begin
            mb_emit = 1'b1;
            mb_kind = rcp_pkg::EV_CHART_END;
            mb_mode = rcp_pkg::MODE_SCAN;
        end else if (b == rcp_pkg::CH_COMMA) begin
            mb_emit = 1'b1;
        end else if (b == rcp_pkg::CH_SLASH) begin
            mb_mode = rcp_pkg::MODE_SLASH;
        end else if (!rcp_pkg::is_space(b)) begin
            mb_row  = 1'b1;
            mb_mode = rcp_pkg::MODE_ROW;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_pos        = r_pos + 1'b1;
        n_span_begin = r_span_begin;
        n_name_begin = r_name_begin;
        n_name_len   = r_name_len;
        n_kw_idx     = r_kw_idx;
        n_kw_miss    = r_kw_miss;
        n_hdr_cnt    = r_hdr_cnt;
        n_row_buf    = r_row_buf;
        n_row_fill   = r_row_fill;
        n_any_hdr    = r_any_hdr;
        n_any_chart  = r_any_chart;
        n_err        = r_err;
        run          = '0;
        ch_done      = 1'b0;
        ch_begin     = r_span_begin;

        unique case (r_mode)
            rcp_pkg::MODE_NAME: begin
                if (b == rcp_pkg::CH_COLON) begin
                    if (!r_kw_miss && (r_kw_idx == 3'(rcp_pkg::NOTES_LEN))) begin
                        run.has_main  = 1'b1;
                        run.main_kind = rcp_pkg::EV_CHART_START;
                        n_any_chart   = 1'b1;
                        n_hdr_cnt     = '0;
                        n_mode        = rcp_pkg::MODE_CH_WS;
                    end else begin
                        n_name_begin = r_span_begin;
                        n_name_len   = r_pos - r_span_begin;
                        n_span_begin = r_pos + 1'b1;
                        n_mode       = rcp_pkg::MODE_VALUE;
                    end
                end else if ((r_kw_idx < 3'(rcp_pkg::NOTES_LEN)) &&
                             (b == rcp_pkg::notes_char(r_kw_idx))) begin
                    n_kw_idx = r_kw_idx + 1'b1;
                end else begin
                    n_kw_miss = 1'b1;
                end
            end
            rcp_pkg::MODE_VALUE: begin
                if (b == rcp_pkg::CH_SEMI) begin
                    run.has_main  = 1'b1;
                    run.main_kind = rcp_pkg::EV_HEADER;
                    run.s1        = to_span(r_name_begin);
                    run.l1        = to_span(r_name_len);
                    run.s2        = to_span(r_span_begin);
                    run.l2        = to_span(r_pos - r_span_begin);
                    n_any_hdr     = 1'b1;
                    n_mode        = rcp_pkg::MODE_SCAN;
                end
            end
            rcp_pkg::MODE_CH_WS: begin
                if (!rcp_pkg::is_space(b)) begin
                    n_span_begin = r_pos;
                    ch_begin     = r_pos;
                    if (b == rcp_pkg::CH_COLON) begin
                        ch_done = 1'b1;
                    end else begin
                        n_mode = rcp_pkg::MODE_CH_TEXT;
                    end
                end
            end
            rcp_pkg::MODE_CH_TEXT: begin
                ch_done = b == rcp_pkg::CH_COLON;
            end
            rcp_pkg::MODE_MEASURES: begin
                n_mode        = mb_mode;
                run.has_main  = mb_emit;
                run.main_kind = mb_kind;
                if (mb_row) begin
                    n_row_buf  = {16'h0000, b};
                    n_row_fill = 2'd1;
                end
            end
            rcp_pkg::MODE_SLASH: begin
                if (b == rcp_pkg::CH_SLASH) begin
                    n_mode = rcp_pkg::MODE_COMMENT;
                end else begin
                    n_row_buf  = {8'h00, b, rcp_pkg::CH_SLASH};
                    n_row_fill = 2'd2;
                    n_mode     = rcp_pkg::MODE_ROW;
                end
            end
            rcp_pkg::MODE_COMMENT: begin
                if (b == rcp_pkg::CH_NL) begin
                    n_mode = rcp_pkg::MODE_MEASURES;
                end
            end
            rcp_pkg::MODE_ROW: begin
                if (r_row_fill != 2'd3) begin
                    n_row_buf  = r_row_buf | (24'(b) << {r_row_fill, 3'b000});
                    n_row_fill = r_row_fill + 1'b1;
                end else if (!fin) begin
                    run.has_main  = 1'b1;
                    run.main_kind = rcp_pkg::EV_ROW;
                    run.row       = {b, r_row_buf};
                    n_row_buf     = '0;
                    n_row_fill    = '0;
                    if (b == rcp_pkg::CH_NL) begin
                        n_mode = rcp_pkg::MODE_MEASURES;
                    end else if (b == rcp_pkg::CH_COMMA || b == rcp_pkg::CH_SEMI) begin
                        run.has_second  = 1'b1;
                        run.second_kind = mb_kind;
                        n_mode          = mb_mode;
                    end else begin
                        n_mode = rcp_pkg::MODE_ROW_SKIP;
                    end
                end
            end
            rcp_pkg::MODE_ROW_SKIP: begin
                if (b == rcp_pkg::CH_NL) begin
                    n_mode = rcp_pkg::MODE_MEASURES;
                end else if (b == rcp_pkg::CH_COMMA || b == rcp_pkg::CH_SEMI) begin
                    run.has_main  = 1'b1;
                    run.main_kind = mb_kind;
                    n_mode        = mb_mode;
                end
            end
            default: begin
                if (b == rcp_pkg::CH_HASH) begin
                    n_span_begin = r_pos + 1'b1;
                    n_kw_idx     = '0;
                    n_kw_miss    = 1'b0;
                    n_mode       = rcp_pkg::MODE_NAME;
                end else begin
                    n_mode = rcp_pkg::MODE_SCAN;
                end
            end
        endcase

        if (ch_done) begin
            run.has_main  = 1'b1;
            run.main_kind = rcp_pkg::EV_CHART_HEADER;
            run.s1        = to_span(ch_begin);
            run.l1        = to_span(r_pos - ch_begin);
            run.hdr_idx   = r_hdr_cnt;
            n_hdr_cnt     = r_hdr_cnt + 1'b1;
            if (r_hdr_cnt >= 3'(rcp_pkg::HEADER_COUNT - 1)) begin
                n_row_buf  = '0;
                n_row_fill = '0;
                n_mode     = rcp_pkg::MODE_MEASURES;
            end else begin
                n_mode = rcp_pkg::MODE_CH_WS;
            end
        end

        // Final byte: give the verdict and drop back to the reset state.
        if (fin) begin
            n_err = r_err || (n_mode != rcp_pkg::MODE_SCAN &&
                              n_mode != rcp_pkg::MODE_CH_WS);
            run.has_verdict = 1'b1;
            run.verdict     = !n_err && n_any_hdr && n_any_chart;
            n_mode       = rcp_pkg::MODE_SCAN;
            n_pos        = '0;
            n_span_begin = '0;
            n_name_begin = '0;
            n_name_len   = '0;
            n_kw_idx     = '0;
            n_kw_miss    = 1'b0;
            n_hdr_cnt    = '0;
            n_row_buf    = '0;
            n_row_fill   = '0;
            n_any_hdr    = 1'b0;
            n_any_chart  = 1'b0;
            n_err        = 1'b0;
        end

        push = in_fire && (run.has_main || run.has_second || run.has_verdict);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= rcp_pkg::MODE_SCAN;
            r_pos        <= '0;
            r_span_begin <= '0;
            r_name_begin <= '0;
            r_name_len   <= '0;
            r_kw_idx     <= '0;
            r_kw_miss    <= 1'b0;
            r_hdr_cnt    <= '0;
            r_row_buf    <= '0;
            r_row_fill   <= '0;
            r_any_hdr    <= 1'b0;
            r_any_chart  <= 1'b0;
            r_err        <= 1'b0;
        end else if (in_fire) begin
            r_mode       <= n_mode;
            r_pos        <= n_pos;
            r_span_begin <= n_span_begin;
            r_name_begin <= n_name_begin;
            r_name_len   <= n_name_len;
            r_kw_idx     <= n_kw_idx;
            r_kw_miss    <= n_kw_miss;
            r_hdr_cnt    <= n_hdr_cnt;
            r_row_buf    <= n_row_buf;
            r_row_fill   <= n_row_fill;
            r_any_hdr    <= n_any_hdr;
            r_any_chart  <= n_any_chart;
            r_err        <= n_err;
        end
    end

    rcp_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run),
        .o_ready (evq_ready),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && fin) |=> (r_pos == '0) && (r_mode == rcp_pkg::MODE_SCAN) &&
                             !r_any_hdr && !r_any_chart && !r_err)
        else $error("state not cleared after final byte");
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire |=> $stable(r_pos) && $stable(r_mode))
        else $error("parser state moved without a byte");
    a_hdr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_cnt <= 3'(rcp_pkg::HEADER_COUNT))
        else $error("chart header count out of range");
    a_final_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && fin) |-> push && run.has_verdict)
        else $error("final byte without verdict record");
`endif

endmodule

`default_nettype wire

// ===== verif/rhythm_chart_text_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhythm_chart_text_parser_tb: self-checking bench for the chart text parser
// Feeds whole chart files byte by byte, mostly well-formed files with random
// headers, chart texts, rows and comments, plus truncated files and noise.
// A software copy of the parser forecasts every event, and each event taken
// from the output channel is compared field by field with the oldest one.
// Both channels stall in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module rhythm_chart_text_parser_tb;

    localparam int RUN_LIMIT    = 200000;
    localparam int RANDOM_BYTES = 400;
    localparam int CALM_BYTES   = 60;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    localparam string NOTES_WORD    = "NOTES";
    localparam string NAME_CHARS    = "ABNOTESXZ_ 9";
    localparam string VALUE_CHARS   = "0123456789.,:AB /#";
    localparam string TEXT_CHARS    = "abcXYZ019.- ";
    localparam string ROW_LEAD      = "0123MKLF/";
    localparam string ROW_CHARS     = "0123MKLF";
    localparam string SKIP_CHARS    = "abc 0x:";
    localparam string COMMENT_CHARS = "abc ,;:#/";
    localparam string SCAN_CHARS    = "ab9 ;:,/";
    localparam string NOISE_CHARS   = "#NOTES:;,/ xa";

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } t_text_byte;

    typedef struct packed {
        rcp_pkg::t_event kind;
        logic [31:0]     s1;
        logic [31:0]     l1;
        logic [31:0]     s2;
        logic [31:0]     l2;
        logic [2:0]      hdr_idx;
        logic [31:0]     row;
        logic            file_ok;
        logic            run_end;
    } t_parse_event;

    logic i_clk;
    logic i_rst_n;

    rcp_in_if  in_ch ();
    rcp_out_if out_ch ();

    rhythm_chart_text_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    t_text_byte   pending_bytes[$];
    t_parse_event expected_events[$];
    logic [7:0]   file_text[$];

    t_text_byte next_byte;
    int         idle_left;
    int         stall_left;
    logic       calm_tail;
    int         cycle_count = 0;
    int         mismatches = 0;
    int         events_checked = 0;
    int         valid_files = 0;
    int         files_built = 0;
    int         directed_bytes;
    int         total_bytes;

    // Parser copy state
    rcp_pkg::t_mode scan_mode;
    logic [31:0]    text_pos;
    logic [31:0]    span_start;
    logic [31:0]    name_start;
    logic [31:0]    name_length;
    logic [2:0]     notes_matched;
    logic           notes_broken;
    logic [2:0]     chart_hdr_count;
    logic [31:0]    row_bytes;
    logic [1:0]     row_count;
    logic           saw_header;
    logic           saw_chart;
    logic           saw_error;

    function automatic logic blank_char(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == rcp_pkg::CH_NL || b == CH_CR ||
               b == CH_VT || b == CH_FF;
    endfunction

    task automatic clear_parser();
        scan_mode       = rcp_pkg::MODE_SCAN;
        text_pos        = '0;
        span_start      = '0;
        name_start      = '0;
        name_length     = '0;
        notes_matched   = '0;
        notes_broken    = 1'b0;
        chart_hdr_count = '0;
        row_bytes       = '0;
        row_count       = '0;
        saw_header      = 1'b0;
        saw_chart       = 1'b0;
        saw_error       = 1'b0;
    endtask

    task automatic emit_event(input rcp_pkg::t_event kind, input logic [31:0] s1,
                              input logic [31:0] l1,
                              input logic [31:0] s2, input logic [31:0] l2,
                              input logic [2:0] idx, input logic [31:0] row,
                              input logic ok);
        t_parse_event ev;
        ev.kind    = kind;
        ev.s1      = s1;
        ev.l1      = l1;
        ev.s2      = s2;
        ev.l2      = l2;
        ev.hdr_idx = idx;
        ev.row     = row;
        ev.file_ok = ok;
        ev.run_end = 1'b0;
        expected_events.push_back(ev);
    endtask

    task automatic measure_char(input logic [7:0] b);
        if (b == rcp_pkg::CH_SEMI) begin
            emit_event(rcp_pkg::EV_CHART_END, 0, 0, 0, 0, 0, 0, 0);
            scan_mode = rcp_pkg::MODE_SCAN;
        end else if (b == rcp_pkg::CH_COMMA) begin
            emit_event(rcp_pkg::EV_MEASURE_END, 0, 0, 0, 0, 0, 0, 0);
            scan_mode = rcp_pkg::MODE_MEASURES;
        end else if (b == rcp_pkg::CH_SLASH) begin
            scan_mode = rcp_pkg::MODE_SLASH;
        end else if (blank_char(b)) begin
            scan_mode = rcp_pkg::MODE_MEASURES;
        end else begin
            row_bytes = {24'b0, b};
            row_count = 2'd1;
            scan_mode = rcp_pkg::MODE_ROW;
        end
    endtask

    task automatic close_chart_header(input logic [31:0] here);
        emit_event(rcp_pkg::EV_CHART_HEADER, span_start, here - span_start, 0, 0,
                   chart_hdr_count, 0, 0);
        chart_hdr_count = chart_hdr_count + 3'd1;
        if (chart_hdr_count >= rcp_pkg::HEADER_COUNT) begin
            row_count = '0;
            row_bytes = '0;
            scan_mode = rcp_pkg::MODE_MEASURES;
        end else begin
            scan_mode = rcp_pkg::MODE_CH_WS;
        end
    endtask

    // Forecast the events of one accepted byte and advance the parser copy.
    task automatic forecast_events(input logic [7:0] b, input logic fin);
        logic [31:0] here;
        int          first_new;
        here = text_pos;
        first_new = expected_events.size();
        case (scan_mode)
            rcp_pkg::MODE_NAME: begin
                if (b == rcp_pkg::CH_COLON) begin
                    if (!notes_broken && notes_matched == rcp_pkg::NOTES_LEN) begin
                        emit_event(rcp_pkg::EV_CHART_START, 0, 0, 0, 0, 0, 0, 0);
                        saw_chart       = 1'b1;
                        chart_hdr_count = '0;
                        scan_mode       = rcp_pkg::MODE_CH_WS;
                    end else begin
                        name_start  = span_start;
                        name_length = here - span_start;
                        span_start  = here + 32'd1;
                        scan_mode   = rcp_pkg::MODE_VALUE;
                    end
                end else if (notes_matched < rcp_pkg::NOTES_LEN &&
                             b == NOTES_WORD[notes_matched]) begin
                    notes_matched = notes_matched + 3'd1;
                end else begin
                    notes_broken = 1'b1;
                end
            end
            rcp_pkg::MODE_VALUE: begin
                if (b == rcp_pkg::CH_SEMI) begin
                    emit_event(rcp_pkg::EV_HEADER, name_start, name_length, span_start,
                               here - span_start, 0, 0, 0);
                    saw_header = 1'b1;
                    scan_mode  = rcp_pkg::MODE_SCAN;
                end
            end
            rcp_pkg::MODE_CH_WS: begin
                if (!blank_char(b)) begin
                    span_start = here;
                    if (b == rcp_pkg::CH_COLON)
                        close_chart_header(here);
                    else
                        scan_mode = rcp_pkg::MODE_CH_TEXT;
                end
            end
            rcp_pkg::MODE_CH_TEXT: begin
                if (b == rcp_pkg::CH_COLON)
                    close_chart_header(here);
            end
            rcp_pkg::MODE_MEASURES: measure_char(b);
            rcp_pkg::MODE_SLASH: begin
                if (b == rcp_pkg::CH_SLASH) begin
                    scan_mode = rcp_pkg::MODE_COMMENT;
                end else begin
                    row_bytes = {16'b0, b, rcp_pkg::CH_SLASH};
                    row_count = 2'd2;
                    scan_mode = rcp_pkg::MODE_ROW;
                end
            end
            rcp_pkg::MODE_COMMENT: begin
                if (b == rcp_pkg::CH_NL)
                    scan_mode = rcp_pkg::MODE_MEASURES;
            end
            rcp_pkg::MODE_ROW: begin
                if (row_count < 2'd3) begin
                    row_bytes = row_bytes | (32'(b) << (8 * row_count));
                    row_count = row_count + 2'd1;
                end else if (!fin) begin
                    // Fourth byte completes the row; it is examined as well
                    emit_event(rcp_pkg::EV_ROW, 0, 0, 0, 0, 0, {b, row_bytes[23:0]}, 0);
                    row_count = '0;
                    row_bytes = '0;
                    if (b == rcp_pkg::CH_NL)
                        scan_mode = rcp_pkg::MODE_MEASURES;
                    else if (b == rcp_pkg::CH_COMMA || b == rcp_pkg::CH_SEMI)
                        measure_char(b);
                    else
                        scan_mode = rcp_pkg::MODE_ROW_SKIP;
                end
            end
            rcp_pkg::MODE_ROW_SKIP: begin
                if (b == rcp_pkg::CH_NL)
                    scan_mode = rcp_pkg::MODE_MEASURES;
                else if (b == rcp_pkg::CH_COMMA || b == rcp_pkg::CH_SEMI)
                    measure_char(b);
            end
            default: begin
                if (b == rcp_pkg::CH_HASH) begin
                    span_start    = here + 32'd1;
                    notes_matched = '0;
                    notes_broken  = 1'b0;
                    scan_mode     = rcp_pkg::MODE_NAME;
                end else begin
                    scan_mode = rcp_pkg::MODE_SCAN;
                end
            end
        endcase
        text_pos = here + 32'd1;
        if (fin) begin
            if (scan_mode != rcp_pkg::MODE_SCAN && scan_mode != rcp_pkg::MODE_CH_WS)
                saw_error = 1'b1;
            emit_event(rcp_pkg::EV_VERDICT, 0, 0, 0, 0, 0, 0,
                       !saw_error && saw_header && saw_chart);
            clear_parser();
        end
        if (expected_events.size() > first_new)
            expected_events[expected_events.size() - 1].run_end = 1'b1;
    endtask

    // ---- file builders ----

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            file_text.push_back(s[i]);
    endtask

    task automatic add_from(input string set, input int n);
        for (int i = 0; i < n; i++)
            file_text.push_back(set[$urandom_range(0, set.len() - 1)]);
    endtask

    task automatic add_blanks(input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0:       c = CH_SPACE;
                1:       c = CH_TAB;
                2:       c = rcp_pkg::CH_NL;
                3:       c = CH_CR;
                4:       c = CH_VT;
                default: c = CH_FF;
            endcase
            file_text.push_back(c);
        end
    endtask

    // Middle row bytes are copied unexamined, so any value goes.
    task automatic add_row_middle();
        if ($urandom_range(0, 1) == 0)
            file_text.push_back(8'($urandom_range(0, 255)));
        else
            add_from(ROW_CHARS, 1);
    endtask

    // tail: 0 newline, 1 skipped text then newline, 2 open (separator follows),
    // 3 three bytes only, so the separator becomes the fourth row byte
    task automatic add_row(input int tail);
        logic [7:0] lead;
        lead = ROW_LEAD[$urandom_range(0, ROW_LEAD.len() - 1)];
        file_text.push_back(lead);
        if (lead == rcp_pkg::CH_SLASH)
            add_from(ROW_CHARS, 1);
        else
            add_row_middle();
        add_row_middle();
        if (tail != 3)
            add_from(ROW_CHARS, 1);
        case (tail)
            0: file_text.push_back(rcp_pkg::CH_NL);
            1: begin
                add_from(SKIP_CHARS, $urandom_range(1, 4));
                file_text.push_back(rcp_pkg::CH_NL);
            end
            2: add_from(SKIP_CHARS, $urandom_range(0, 3));
            default: ;
        endcase
    endtask

    task automatic add_header();
        file_text.push_back(rcp_pkg::CH_HASH);
        case ($urandom_range(0, 6))
            0: add_str("NOTE");
            1: add_str("NOTESX");
            2: add_str("NOTXS");
            3: add_str("notes");
            4: ;
            default: add_from(NAME_CHARS, $urandom_range(1, 6));
        endcase
        file_text.push_back(rcp_pkg::CH_COLON);
        add_from(VALUE_CHARS, $urandom_range(0, 8));
        file_text.push_back(rcp_pkg::CH_SEMI);
    endtask

    task automatic add_chart();
        int n_meas;
        int n_items;
        add_str("#NOTES:");
        for (int h = 0; h < rcp_pkg::HEADER_COUNT; h++) begin
            add_blanks($urandom_range(0, 2));
            add_from(TEXT_CHARS, $urandom_range(0, 5));
            file_text.push_back(rcp_pkg::CH_COLON);
        end
        add_blanks($urandom_range(0, 2));
        n_meas = $urandom_range(1, 3);
        for (int m = 0; m < n_meas; m++) begin
            n_items = $urandom_range(0, 3);
            for (int i = 0; i < n_items; i++) begin
                case ($urandom_range(0, 9))
                    6, 7: begin
                        add_str("//");
                        add_from(COMMENT_CHARS, $urandom_range(0, 6));
                        file_text.push_back(rcp_pkg::CH_NL);
                    end
                    8, 9: add_blanks($urandom_range(1, 3));
                    default: add_row(i == n_items - 1 ? $urandom_range(0, 3)
                                                      : $urandom_range(0, 1));
                endcase
            end
            file_text.push_back(m == n_meas - 1 ? rcp_pkg::CH_SEMI : rcp_pkg::CH_COMMA);
        end
    endtask

    task automatic add_file_body();
        int n_charts;
        for (int i = $urandom_range(0, 2); i > 0; i--) begin
            add_from(SCAN_CHARS, $urandom_range(0, 3));
            add_header();
        end
        n_charts = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
        for (int i = 0; i < n_charts; i++) begin
            add_from(SCAN_CHARS, $urandom_range(0, 3));
            add_chart();
            if ($urandom_range(0, 2) == 0)
                add_header();
        end
        add_blanks($urandom_range(0, 2));
    endtask

    // Move the built file into the request queue, marking its last byte.
    task automatic commit_file(input bit cut);
        int keep;
        t_text_byte tb;
        if (file_text.size() == 0)
            add_from(SCAN_CHARS, 1);
        if (cut && file_text.size() > 1) begin
            keep = $urandom_range(1, file_text.size() - 1);
            while (file_text.size() > keep)
                void'(file_text.pop_back());
        end
        for (int i = 0; i < file_text.size(); i++) begin
            tb.value   = file_text[i];
            tb.is_last = (i == file_text.size() - 1);
            pending_bytes.push_back(tb);
        end
        file_text.delete();
        files_built++;
    endtask

    // ---- request driver ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            idle_left   <= 0;
            calm_tail   <= 1'b0;
        end else begin
            calm_tail <= (pending_bytes.size() < CALM_BYTES);
            if (in_ch.valid && in_ch.ready)
                forecast_events(in_ch.data_byte, in_ch.final_byte);
            if (!in_ch.valid || in_ch.ready) begin
                if (idle_left != 0) begin
                    in_ch.valid <= 1'b0;
                    idle_left   <= idle_left - 1;
                end else if (pending_bytes.size() != 0) begin
                    next_byte = pending_bytes.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.data_byte  <= next_byte.value;
                    in_ch.final_byte <= next_byte.is_last;
                    if (!calm_tail && $urandom_range(0, 7) == 0)
                        idle_left <= $urandom_range(1, 19);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ---- event monitor ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event, expected none, got kind %0d", $time,
                             out_ch.event_kind);
                    mismatches++;
                end else begin
                    check_field("event_kind", expected_events[0].kind, out_ch.event_kind);
                    check_field("first_span_start", expected_events[0].s1,
                                out_ch.first_span_start);
                    check_field("first_span_length", expected_events[0].l1,
                                out_ch.first_span_length);
                    check_field("second_span_start", expected_events[0].s2,
                                out_ch.second_span_start);
                    check_field("second_span_length", expected_events[0].l2,
                                out_ch.second_span_length);
                    check_field("chart_header_index", expected_events[0].hdr_idx,
                                out_ch.chart_header_index);
                    check_field("row_characters", expected_events[0].row,
                                out_ch.row_characters);
                    check_field("file_valid", expected_events[0].file_ok, out_ch.file_valid);
                    check_field("last_of_run", expected_events[0].run_end, out_ch.last_of_run);
                    if (expected_events[0].kind == rcp_pkg::EV_VERDICT &&
                        expected_events[0].file_ok)
                        valid_files++;
                    void'(expected_events.pop_front());
                    events_checked++;
                end
            end
            if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end else begin
                out_ch.ready <= 1'b1;
                if (!calm_tail && $urandom_range(0, 7) == 0)
                    stall_left <= $urandom_range(1, 19);
            end
        end
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("%0t: timeout, %0d events still expected", $time, expected_events.size());
        $display("FAIL rhythm_chart_text_parser");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.final_byte = 1'b0;
        out_ch.ready     = 1'b0;
        clear_parser();

        // Extreme byte values in a file with no header or chart
        file_text.push_back(8'h00);
        file_text.push_back(8'hFF);
        commit_file(0);
        // File ending in the whitespace before a chart header: valid
        add_str("#A:b;#NOTES:");
        file_text.push_back(CH_TAB);
        commit_file(0);
        // Lone slash row cut off at its fourth byte
        add_str("#NOTES::::::/ab;");
        commit_file(0);
        directed_bytes = pending_bytes.size();

        while (pending_bytes.size() < directed_bytes + RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                7: begin
                    add_file_body();
                    commit_file(1);
                end
                8: begin
                    for (int i = $urandom_range(1, 16); i > 0; i--)
                        file_text.push_back(8'($urandom_range(0, 255)));
                    commit_file(0);
                end
                9: begin
                    add_from(NOISE_CHARS, $urandom_range(1, 30));
                    commit_file(0);
                end
                default: begin
                    add_file_body();
                    commit_file(0);
                end
            endcase
        end
        total_bytes = pending_bytes.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        while (expected_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Parsed %0d files (%0d bytes), checked %0d events, %0d files judged valid.",
                 files_built, total_bytes, events_checked, valid_files);
        if (mismatches == 0) begin
            $display("PASS rhythm_chart_text_parser");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL rhythm_chart_text_parser");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rcp_pkg.sv
rtl/rcp_in_if.sv
rtl/rcp_out_if.sv
rtl/rcp_evq.sv
rtl/rhythm_chart_text_parser.sv
verif/rhythm_chart_text_parser_tb.sv
